// ===== sv/quic_header_packet_length_parser_top_defines.svh =====
// Assertion macros for the checker file of the QUIC header length parser.
`ifndef QUIC_HEADER_PACKET_LENGTH_PARSER_TOP_DEFINES_SVH
`define QUIC_HEADER_PACKET_LENGTH_PARSER_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is low.
`define QHPL_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define QHPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/qhpl_pkg.sv =====
// Types, constants and helper functions of the QUIC header length parser.
package qhpl_pkg;

    localparam int MaxDatagramBytes = 65535;
    localparam int POS_W  = $clog2(MaxDatagramBytes + 1);
    localparam int DATA_W = 8;
    localparam int CID_W  = 5;
    localparam int LEN_W  = 63;
    localparam int VAR_W  = 62;
    localparam int KIND_W = 3;
    localparam int STAT_W = 4;
    localparam int VLEFT_W = 3;
    localparam int PN_W   = 3;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MaxDatagramBytes);
    localparam logic [CID_W-1:0] CID_LEN_RESET = CID_W'(8);
    localparam logic [VAR_W-1:0] VERSION_BYTES = VAR_W'(4);

    localparam logic [KIND_W-1:0] KIND_INITIAL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO_RTT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETRY     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SHORT     = 3'd4;

    typedef enum logic [3:0] {
        PH_FIRST     = 4'd0,
        PH_VERSION   = 4'd1,
        PH_DCID_LEN  = 4'd2,
        PH_DCID      = 4'd3,
        PH_SCID_LEN  = 4'd4,
        PH_SCID      = 4'd5,
        PH_TOKLEN    = 4'd6,
        PH_TOKEN     = 4'd7,
        PH_LEN       = 4'd8,
        PH_PN        = 4'd9,
        PH_RETRY_LEN = 4'd10,
        PH_RETRY     = 4'd11,
        PH_SHORT     = 4'd12,
        PH_DONE      = 4'd13
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 4'd0,
        ST_FIXED_CUT = 4'd1,
        ST_DCID_CUT  = 4'd2,
        ST_SCID_CUT  = 4'd3,
        ST_TOKLEN_CUT = 4'd4,
        ST_TOKEN_CUT = 4'd5,
        ST_LEN_CUT   = 4'd6,
        ST_PN_CUT    = 4'd7,
        ST_RETRY_CUT = 4'd8,
        ST_SHORT_CUT = 4'd9,
        ST_EMPTY     = 4'd10
    } t_status;

    function automatic logic [KIND_W-1:0] kind_of(input logic [DATA_W-1:0] first);
        logic [KIND_W-1:0] k;
        if (!first[7]) begin
            k = KIND_SHORT;
        end else begin
            k = {1'b0, first[5:4]};
        end
        return k;
    endfunction

    function automatic logic [PN_W-1:0] pn_size(input logic [DATA_W-1:0] first);
        return {1'b0, first[1:0]} + PN_W'(1);
    endfunction

    function automatic t_phase after_scid(input logic [DATA_W-1:0] first);
        t_phase p;
        case (kind_of(first))
            KIND_INITIAL: p = PH_TOKLEN;
            KIND_RETRY:   p = PH_RETRY_LEN;
            default:      p = PH_LEN;
        endcase
        return p;
    endfunction

    function automatic t_status phase_status(input t_phase p);
        t_status s;
        case (p)
            PH_VERSION:   s = ST_FIXED_CUT;
            PH_DCID_LEN:  s = ST_DCID_CUT;
            PH_DCID:      s = ST_DCID_CUT;
            PH_SCID_LEN:  s = ST_SCID_CUT;
            PH_SCID:      s = ST_SCID_CUT;
            PH_TOKLEN:    s = ST_TOKLEN_CUT;
            PH_TOKEN:     s = ST_TOKEN_CUT;
            PH_LEN:       s = ST_LEN_CUT;
            PH_PN:        s = ST_PN_CUT;
            PH_RETRY_LEN: s = ST_RETRY_CUT;
            PH_RETRY:     s = ST_RETRY_CUT;
            PH_SHORT:     s = ST_SHORT_CUT;
            default:      s = ST_OK;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/qhpl_ifs.sv =====
// Channel interfaces of the QUIC header length parser: byte input, result output, config.
interface qhpl_byte_if;
    logic                          valid;
    logic                          ready;
    logic [qhpl_pkg::DATA_W-1:0]   data_byte;
    logic                          last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface qhpl_result_if;
    logic                          valid;
    logic                          ready;
    logic [qhpl_pkg::LEN_W-1:0]    packet_length;
    logic [qhpl_pkg::KIND_W-1:0]   header_kind;
    logic [qhpl_pkg::STAT_W-1:0]   status;
    modport source (output valid, output packet_length, output header_kind, output status,
                    input ready);
    modport sink   (input valid, input packet_length, input header_kind, input status,
                    output ready);
endinterface

interface qhpl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qhpl_pkg::CID_W-1:0]    short_conn_id_length;
    modport source (output valid, output short_conn_id_length, input ready);
    modport sink   (input valid, input short_conn_id_length, output ready);
endinterface

// ===== sv/quic_header_packet_length_parser_top.sv =====
// Top level of the QUIC packet header length parser.
// The byte channel i_byte carries one datagram byte per transaction, first byte
// first, with last_byte set on the final byte of the datagram.
// The result channel o_result carries one transaction per datagram: the packet
// length, the header kind and a status; the length is zero unless status is ok.
// The config channel i_cfg writes the short-header connection ID length; it is
// always ready and should only be written while no datagram is in flight.
// Each accepted byte updates the parse state in the cycle it is accepted, so
// the block takes one byte per cycle, with no gaps between datagrams, unless
// the result register is stalled. The result appears in the output register
// in the cycle after the last byte is accepted.
// If the receiver stalls, the result holds in the output register and the byte
// channel is held not ready until that result transaction is taken.
// Reset is synchronous and active low; it returns the parser to the first-byte
// phase, sets the connection ID length to eight and drops the result valid.
module quic_header_packet_length_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qhpl_byte_if.sink           i_byte,
    qhpl_result_if.source       o_result,
    qhpl_cfg_if.sink            i_cfg
);

    logic [qhpl_pkg::CID_W-1:0]   r_cid_len;
    qhpl_pkg::t_phase             r_phase, n_phase;
    logic [qhpl_pkg::DATA_W-1:0]  r_first, n_first;
    logic [qhpl_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [qhpl_pkg::POS_W-1:0]   r_hbc, n_hbc;
    logic [qhpl_pkg::VAR_W-1:0]   r_skip, n_skip;
    logic [qhpl_pkg::VAR_W-1:0]   r_acc, n_acc;
    logic [qhpl_pkg::VLEFT_W-1:0] r_left, n_left;
    logic [qhpl_pkg::VAR_W-1:0]   r_payload, n_payload;

    logic                         r_out_valid;
    logic [qhpl_pkg::LEN_W-1:0]   r_out_len, n_out_len;
    logic [qhpl_pkg::KIND_W-1:0]  r_out_kind, n_out_kind;
    qhpl_pkg::t_status            r_out_status, n_out_status;

    logic                         in_fire;
    logic                         skip_done;
    logic [qhpl_pkg::VAR_W-1:0]   skip_dec;
    logic [qhpl_pkg::VAR_W-1:0]   v_acc;
    logic [qhpl_pkg::VLEFT_W-1:0] v_left;
    logic                         v_done;
    logic [qhpl_pkg::DATA_W-1:0]  b;

    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;
    assign b            = i_byte.data_byte;

    assign o_result.valid         = r_out_valid;
    assign o_result.packet_length = r_out_len;
    assign o_result.header_kind   = r_out_kind;
    assign o_result.status        = r_out_status;

    assign skip_dec  = r_skip - qhpl_pkg::VAR_W'(1);
    assign skip_done = (skip_dec == '0);

    always_comb begin
        if (r_left == '0) begin
            v_acc = {{(qhpl_pkg::VAR_W - 6){1'b0}}, b[5:0]};
            case (b[7:6])
                2'd0:    v_left = 3'd0;
                2'd1:    v_left = 3'd1;
                2'd2:    v_left = 3'd3;
                default: v_left = 3'd7;
            endcase
        end else begin
            v_acc  = {r_acc[qhpl_pkg::VAR_W-9:0], b};
            v_left = r_left - qhpl_pkg::VLEFT_W'(1);
        end
        v_done = (v_left == '0);
    end

    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_pos     = (r_pos < qhpl_pkg::MAX_POS) ? r_pos + qhpl_pkg::POS_W'(1) : r_pos;
        n_hbc     = r_hbc;
        n_skip    = r_skip;
        n_acc     = r_acc;
        n_left    = r_left;
        n_payload = r_payload;

        case (r_phase)
            qhpl_pkg::PH_FIRST: begin
                n_first = b;
                if (b[7]) begin
                    n_skip  = qhpl_pkg::VERSION_BYTES;
                    n_phase = qhpl_pkg::PH_VERSION;
                end else begin
                    n_skip  = qhpl_pkg::VAR_W'(r_cid_len)
                            + qhpl_pkg::VAR_W'(qhpl_pkg::pn_size(b));
                    n_phase = qhpl_pkg::PH_SHORT;
                end
            end
            qhpl_pkg::PH_VERSION: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = qhpl_pkg::PH_DCID_LEN;
            end
            qhpl_pkg::PH_DCID_LEN: begin
                n_skip  = qhpl_pkg::VAR_W'(b);
                n_phase = (b == '0) ? qhpl_pkg::PH_SCID_LEN : qhpl_pkg::PH_DCID;
            end
            qhpl_pkg::PH_DCID: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = qhpl_pkg::PH_SCID_LEN;
            end
            qhpl_pkg::PH_SCID_LEN: begin
                n_skip  = qhpl_pkg::VAR_W'(b);
                n_phase = (b == '0) ? qhpl_pkg::after_scid(r_first) : qhpl_pkg::PH_SCID;
            end
            qhpl_pkg::PH_SCID: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = qhpl_pkg::after_scid(r_first);
            end
            qhpl_pkg::PH_TOKLEN: begin
                n_acc  = v_acc;
                n_left = v_left;
                if (v_done) begin
                    n_skip  = v_acc;
                    n_phase = (v_acc == '0) ? qhpl_pkg::PH_LEN : qhpl_pkg::PH_TOKEN;
                end
            end
            qhpl_pkg::PH_TOKEN: begin
                n_skip = skip_dec;
                if (skip_done) n_phase = qhpl_pkg::PH_LEN;
            end
            qhpl_pkg::PH_LEN: begin
                n_acc  = v_acc;
                n_left = v_left;
                if (v_done) begin
                    n_payload = v_acc;
                    n_skip    = qhpl_pkg::VAR_W'(qhpl_pkg::pn_size(r_first));
                    n_phase   = qhpl_pkg::PH_PN;
                end
            end
            qhpl_pkg::PH_RETRY_LEN: begin
                n_payload = '0;
                n_skip    = qhpl_pkg::VAR_W'(b);
                if (b == '0) begin
                    n_hbc   = n_pos;
                    n_phase = qhpl_pkg::PH_DONE;
                end else begin
                    n_phase = qhpl_pkg::PH_RETRY;
                end
            end
            qhpl_pkg::PH_PN, qhpl_pkg::PH_RETRY, qhpl_pkg::PH_SHORT: begin
                n_skip = skip_dec;
                if (skip_done) begin
                    n_hbc   = n_pos;
                    n_phase = qhpl_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase

        n_out_kind   = qhpl_pkg::kind_of(n_first);
        n_out_status = qhpl_pkg::phase_status(n_phase);
        if (n_out_status != qhpl_pkg::ST_OK) begin
            n_out_len = '0;
        end else if (n_out_kind == qhpl_pkg::KIND_SHORT) begin
            n_out_len = qhpl_pkg::LEN_W'(n_pos);
        end else begin
            n_out_len = qhpl_pkg::LEN_W'(n_hbc) + qhpl_pkg::LEN_W'(n_payload);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cid_len <= qhpl_pkg::CID_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_cid_len <= i_cfg.short_conn_id_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= qhpl_pkg::PH_FIRST;
            r_first   <= '0;
            r_pos     <= '0;
            r_hbc     <= '0;
            r_skip    <= '0;
            r_acc     <= '0;
            r_left    <= '0;
            r_payload <= '0;
        end else if (in_fire) begin
            if (i_byte.last_byte) begin
                r_phase   <= qhpl_pkg::PH_FIRST;
                r_first   <= '0;
                r_pos     <= '0;
                r_hbc     <= '0;
                r_skip    <= '0;
                r_acc     <= '0;
                r_left    <= '0;
                r_payload <= '0;
            end else begin
                r_phase   <= n_phase;
                r_first   <= n_first;
                r_pos     <= n_pos;
                r_hbc     <= n_hbc;
                r_skip    <= n_skip;
                r_acc     <= n_acc;
                r_left    <= n_left;
                r_payload <= n_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_byte.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_byte.last_byte) begin
            r_out_len    <= n_out_len;
            r_out_kind   <= n_out_kind;
            r_out_status <= n_out_status;
        end
    end

endmodule

// ===== sv/qhpl_checker.sv =====
// Port-level assertions for the QUIC header length parser and their bind.
`include "quic_header_packet_length_parser_top_defines.svh"

module qhpl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_last,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [qhpl_pkg::LEN_W-1:0]    i_out_len,
    input logic [qhpl_pkg::KIND_W-1:0]   i_out_kind,
    input logic [qhpl_pkg::STAT_W-1:0]   i_out_status
);

    `QHPL_ASSERT_RST(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_len) && $stable(i_out_kind) && $stable(i_out_status), "Stalled result changed.")

    `QHPL_ASSERT_RST(a_error_zero_len, i_clk, i_rst_n, i_out_valid && (i_out_status != qhpl_pkg::ST_OK) |-> (i_out_len == '0), "Length is not zero on an error status.")

    `QHPL_ASSERT_RST(a_result_from_last, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last), "Result without a last byte.")

    `QHPL_ASSERT_RST(a_codes_in_range, i_clk, i_rst_n, i_out_valid |-> (i_out_kind <= qhpl_pkg::KIND_SHORT) && (i_out_status <= qhpl_pkg::ST_SHORT_CUT), "Kind or status code out of range.")

    `QHPL_ASSERT_ALWAYS(a_backpressure, i_clk, i_out_valid && !i_out_ready |-> !i_in_ready, "Input ready while the result register is stalled.")

endmodule

bind quic_header_packet_length_parser_top qhpl_checker u_qhpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte.valid),
    .i_in_ready   (i_byte.ready),
    .i_in_last    (i_byte.last_byte),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_len    (o_result.packet_length),
    .i_out_kind   (o_result.header_kind),
    .i_out_status (o_result.status)
);

// ===== tb/quic_header_packet_length_parser_top_test.sv =====
// Self-checking testbench of the QUIC packet header length parser top level.
`timescale 1ns / 100ps

module quic_header_packet_length_parser_top_test;

    typedef struct packed {
        logic [qhpl_pkg::LEN_W-1:0]  length;
        logic [qhpl_pkg::KIND_W-1:0] kind;
        qhpl_pkg::t_status           status;
    } t_parse_result;

    typedef struct packed {
        logic [7:0]                  first;
        logic [7:0]                  dcid_len;
        logic [7:0]                  scid_len;
        logic [3:0]                  tok_size;
        logic [qhpl_pkg::VAR_W-1:0]  tok_val;
        logic [3:0]                  len_size;
        logic [qhpl_pkg::VAR_W-1:0]  len_val;
        logic [7:0]                  retry_len;
        int                          trail;
        int                          cut;
        bit                          typed;
        logic [qhpl_pkg::LEN_W-1:0]  exp_len;
        logic [qhpl_pkg::KIND_W-1:0] exp_kind;
        qhpl_pkg::t_status           exp_status;
    } t_dgram_row;

    // A cut of zero sends the whole datagram; typed rows carry their own expected result.
    // first  dcid   scid   tsz   tok_val  lsz   len_val  rlen  trail cut typed length kind status
    localparam t_dgram_row DIRECTED [24] = '{
        '{8'h00, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 1, 1'b1, 63'd0,
          qhpl_pkg::KIND_SHORT, qhpl_pkg::ST_SHORT_CUT},
        '{8'hC0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 1, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_FIXED_CUT},
        '{8'hFF, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 1, 1'b1, 63'd0,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_FIXED_CUT},
        '{8'hC0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 5, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_DCID_CUT},
        '{8'hE0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 7, 1'b1, 63'd0,
          qhpl_pkg::KIND_HANDSHAKE, qhpl_pkg::ST_LEN_CUT},
        '{8'hC0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 7, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_TOKLEN_CUT},
        '{8'hF0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 7, 1'b1, 63'd0,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_RETRY_CUT},
        '{8'hF0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 0, 1'b1, 63'd8,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_OK},
        '{8'hC0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 0, 1'b1, 63'd10,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_OK},
        '{8'hE3, 8'd20, 8'd20, 4'd1, 62'd0, 4'd8, 62'h3FFF_FFFF_FFFF_FFFF, 8'd0, 0, 0,
          1'b1, 63'h4000_0000_0000_003A, qhpl_pkg::KIND_HANDSHAKE, qhpl_pkg::ST_OK},
        '{8'hD1, 8'd12, 8'd9, 4'd1, 62'd0, 4'd2, 62'd1000, 8'd0, 5, 0, 1'b0, 63'd0,
          qhpl_pkg::KIND_ZERO_RTT, qhpl_pkg::ST_OK},
        '{8'hC1, 8'd3, 8'd5, 4'd4, 62'd3, 4'd4, 62'd70000, 8'd0, 2, 0, 1'b0, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_OK},
        '{8'hC0, 8'd0, 8'd0, 4'd1, 62'd10, 4'd1, 62'd0, 8'd0, 0, 10, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_TOKEN_CUT},
        '{8'hC0, 8'd0, 8'd0, 4'd2, 62'd300, 4'd1, 62'd0, 8'd0, 0, 8, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_TOKLEN_CUT},
        '{8'hE0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd8, 62'd5, 8'd0, 0, 10, 1'b1, 63'd0,
          qhpl_pkg::KIND_HANDSHAKE, qhpl_pkg::ST_LEN_CUT},
        '{8'hE3, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd9, 8'd0, 0, 10, 1'b1, 63'd0,
          qhpl_pkg::KIND_HANDSHAKE, qhpl_pkg::ST_PN_CUT},
        '{8'hF3, 8'd4, 8'd4, 4'd1, 62'd0, 4'd1, 62'd0, 8'd20, 3, 0, 1'b0, 63'd0,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_OK},
        '{8'hF0, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd20, 0, 12, 1'b1, 63'd0,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_RETRY_CUT},
        '{8'hC0, 8'd10, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 9, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_DCID_CUT},
        '{8'hC0, 8'd0, 8'd10, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 9, 1'b1, 63'd0,
          qhpl_pkg::KIND_INITIAL, qhpl_pkg::ST_SCID_CUT},
        '{8'h40, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 3, 0, 1'b1, 63'd13,
          qhpl_pkg::KIND_SHORT, qhpl_pkg::ST_OK},
        '{8'h7F, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 0, 5, 1'b1, 63'd0,
          qhpl_pkg::KIND_SHORT, qhpl_pkg::ST_SHORT_CUT},
        '{8'hBF, 8'd2, 8'd2, 4'd1, 62'd0, 4'd1, 62'd0, 8'd3, 1, 0, 1'b0, 63'd0,
          qhpl_pkg::KIND_RETRY, qhpl_pkg::ST_OK},
        '{8'h00, 8'd0, 8'd0, 4'd1, 62'd0, 4'd1, 62'd0, 8'd0, 20, 0, 1'b0, 63'd0,
          qhpl_pkg::KIND_SHORT, qhpl_pkg::ST_OK}
    };

    logic i_clk;
    logic i_rst_n;

    qhpl_byte_if   byte_ch ();
    qhpl_result_if res_ch ();
    qhpl_cfg_if    cfg_ch ();

    quic_header_packet_length_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    t_parse_result awaited_results [$];
    logic [7:0]    dgram_bytes [$];
    int            mismatch_count = 0;
    bit            steady = 1'b0;

    logic [qhpl_pkg::CID_W-1:0] cid_bytes;
    qhpl_pkg::t_phase           hdr_phase;
    logic [7:0]                 lead_byte;
    int                         dgram_pos;
    int                         hdr_len;
    logic [qhpl_pkg::VAR_W-1:0] skip_left;
    logic [qhpl_pkg::VAR_W-1:0] vint_acc;
    logic [3:0]                 vint_left;
    logic [qhpl_pkg::VAR_W-1:0] len_value;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_parse();
        hdr_phase = qhpl_pkg::PH_FIRST;
        lead_byte = '0;
        dgram_pos = 0;
        hdr_len = 0;
        skip_left = '0;
        vint_acc = '0;
        vint_left = '0;
        len_value = '0;
    endfunction

    function automatic logic [qhpl_pkg::KIND_W-1:0] lead_kind();
        if (!lead_byte[7]) begin
            return qhpl_pkg::KIND_SHORT;
        end
        return {1'b0, lead_byte[5:4]};
    endfunction

    function automatic logic [qhpl_pkg::VAR_W-1:0] pn_count();
        return qhpl_pkg::VAR_W'(lead_byte[1:0]) + qhpl_pkg::VAR_W'(1);
    endfunction

    function automatic void seal_header();
        hdr_len = dgram_pos;
        hdr_phase = qhpl_pkg::PH_DONE;
    endfunction

    function automatic void enter_post_scid();
        case (lead_kind())
            qhpl_pkg::KIND_INITIAL: hdr_phase = qhpl_pkg::PH_TOKLEN;
            qhpl_pkg::KIND_RETRY:   hdr_phase = qhpl_pkg::PH_RETRY_LEN;
            default:                hdr_phase = qhpl_pkg::PH_LEN;
        endcase
    endfunction

    function automatic bit take_varint(input logic [7:0] b);
        if (vint_left == 0) begin
            vint_acc = qhpl_pkg::VAR_W'(b[5:0]);
            vint_left = (4'd1 << b[7:6]) - 4'd1;
        end else begin
            vint_acc = {vint_acc[qhpl_pkg::VAR_W-9:0], b};
            vint_left = vint_left - 4'd1;
        end
        return vint_left == 0;
    endfunction

    function automatic bit skip_one();
        skip_left = skip_left - qhpl_pkg::VAR_W'(1);
        return skip_left == 0;
    endfunction

    function automatic qhpl_pkg::t_status cut_status();
        case (hdr_phase)
            qhpl_pkg::PH_VERSION:                     return qhpl_pkg::ST_FIXED_CUT;
            qhpl_pkg::PH_DCID_LEN, qhpl_pkg::PH_DCID: return qhpl_pkg::ST_DCID_CUT;
            qhpl_pkg::PH_SCID_LEN, qhpl_pkg::PH_SCID: return qhpl_pkg::ST_SCID_CUT;
            qhpl_pkg::PH_TOKLEN:                      return qhpl_pkg::ST_TOKLEN_CUT;
            qhpl_pkg::PH_TOKEN:                       return qhpl_pkg::ST_TOKEN_CUT;
            qhpl_pkg::PH_LEN:                         return qhpl_pkg::ST_LEN_CUT;
            qhpl_pkg::PH_PN:                          return qhpl_pkg::ST_PN_CUT;
            qhpl_pkg::PH_RETRY_LEN, qhpl_pkg::PH_RETRY:
                                                      return qhpl_pkg::ST_RETRY_CUT;
            qhpl_pkg::PH_SHORT:                       return qhpl_pkg::ST_SHORT_CUT;
            default:                                  return qhpl_pkg::ST_OK;
        endcase
    endfunction

    function automatic bit track_byte(input logic [7:0] b, input bit last,
                                      output t_parse_result res);
        res = '0;
        if (dgram_pos < qhpl_pkg::MaxDatagramBytes) begin
            dgram_pos++;
        end
        case (hdr_phase)
            qhpl_pkg::PH_FIRST: begin
                lead_byte = b;
                if (b[7]) begin
                    skip_left = qhpl_pkg::VERSION_BYTES;
                    hdr_phase = qhpl_pkg::PH_VERSION;
                end else begin
                    skip_left = qhpl_pkg::VAR_W'(cid_bytes) + pn_count();
                    hdr_phase = qhpl_pkg::PH_SHORT;
                end
            end
            qhpl_pkg::PH_VERSION: begin
                if (skip_one()) hdr_phase = qhpl_pkg::PH_DCID_LEN;
            end
            qhpl_pkg::PH_DCID_LEN: begin
                skip_left = qhpl_pkg::VAR_W'(b);
                hdr_phase = (b == 0) ? qhpl_pkg::PH_SCID_LEN : qhpl_pkg::PH_DCID;
            end
            qhpl_pkg::PH_DCID: begin
                if (skip_one()) hdr_phase = qhpl_pkg::PH_SCID_LEN;
            end
            qhpl_pkg::PH_SCID_LEN: begin
                skip_left = qhpl_pkg::VAR_W'(b);
                if (b == 0) enter_post_scid();
                else hdr_phase = qhpl_pkg::PH_SCID;
            end
            qhpl_pkg::PH_SCID: begin
                if (skip_one()) enter_post_scid();
            end
            qhpl_pkg::PH_TOKLEN: begin
                if (take_varint(b)) begin
                    skip_left = vint_acc;
                    hdr_phase = (vint_acc == 0) ? qhpl_pkg::PH_LEN : qhpl_pkg::PH_TOKEN;
                end
            end
            qhpl_pkg::PH_TOKEN: begin
                if (skip_one()) hdr_phase = qhpl_pkg::PH_LEN;
            end
            qhpl_pkg::PH_LEN: begin
                if (take_varint(b)) begin
                    len_value = vint_acc;
                    skip_left = pn_count();
                    hdr_phase = qhpl_pkg::PH_PN;
                end
            end
            qhpl_pkg::PH_RETRY_LEN: begin
                len_value = '0;
                skip_left = qhpl_pkg::VAR_W'(b);
                if (b == 0) seal_header();
                else hdr_phase = qhpl_pkg::PH_RETRY;
            end
            qhpl_pkg::PH_PN, qhpl_pkg::PH_RETRY, qhpl_pkg::PH_SHORT: begin
                if (skip_one()) seal_header();
            end
            default: ;
        endcase
        if (!last) begin
            return 1'b0;
        end
        res.kind = lead_kind();
        res.status = cut_status();
        if (res.status == qhpl_pkg::ST_OK) begin
            res.length = (res.kind == qhpl_pkg::KIND_SHORT)
                       ? qhpl_pkg::LEN_W'(dgram_pos)
                       : qhpl_pkg::LEN_W'(hdr_len) + qhpl_pkg::LEN_W'(len_value);
        end
        reset_parse();
        return 1'b1;
    endfunction

    function automatic int idle_span();
        int pick;
        if (steady) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] field_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return 8'($urandom_range(0, 8));
        if (pick < 97) return 8'($urandom_range(9, 20));
        return 8'($urandom_range(21, 255));
    endfunction

    function automatic void put_varint(input logic [3:0] size,
                                       input logic [qhpl_pkg::VAR_W-1:0] val);
        logic [63:0] word;
        int          nbits;
        nbits = 8 * int'(size);
        word = 64'(val) & ((64'd1 << (nbits - 2)) - 64'd1);
        word = word | (64'($clog2(size)) << (nbits - 2));
        for (int i = int'(size) - 1; i >= 0; i--) begin
            dgram_bytes.push_back(word[8*i +: 8]);
        end
    endfunction

    function automatic void build_row(input t_dgram_row r);
        int tok_n;
        dgram_bytes.delete();
        dgram_bytes.push_back(r.first);
        if (!r.first[7]) begin
            repeat (int'(cid_bytes) + int'(r.first[1:0]) + 1)
                dgram_bytes.push_back(8'($urandom));
        end else begin
            repeat (4) dgram_bytes.push_back(8'($urandom));
            dgram_bytes.push_back(r.dcid_len);
            repeat (r.dcid_len) dgram_bytes.push_back(8'($urandom));
            dgram_bytes.push_back(r.scid_len);
            repeat (r.scid_len) dgram_bytes.push_back(8'($urandom));
            case ({1'b0, r.first[5:4]})
                qhpl_pkg::KIND_RETRY: begin
                    dgram_bytes.push_back(r.retry_len);
                    repeat (r.retry_len) dgram_bytes.push_back(8'($urandom));
                end
                default: begin
                    if ({1'b0, r.first[5:4]} == qhpl_pkg::KIND_INITIAL) begin
                        tok_n = (r.tok_val > 24) ? 24 : int'(r.tok_val);
                        put_varint(r.tok_size, r.tok_val);
                        repeat (tok_n) dgram_bytes.push_back(8'($urandom));
                    end
                    put_varint(r.len_size, r.len_val);
                    repeat (int'(r.first[1:0]) + 1) dgram_bytes.push_back(8'($urandom));
                end
            endcase
        end
        repeat (r.trail) dgram_bytes.push_back(8'($urandom));
        if (r.cut > 0) begin
            while (dgram_bytes.size() > r.cut) void'(dgram_bytes.pop_back());
        end
    endfunction

    function automatic t_dgram_row rand_row();
        t_dgram_row r;
        r = '0;
        r.first = 8'($urandom);
        r.first[7] = ($urandom_range(0, 99) >= 25);
        r.dcid_len = field_len();
        r.scid_len = field_len();
        r.retry_len = field_len();
        r.tok_size = 4'(1 << $urandom_range(0, 3));
        r.tok_val = ($urandom_range(0, 4) == 0)
                  ? qhpl_pkg::VAR_W'({$urandom, $urandom})
                  : qhpl_pkg::VAR_W'($urandom_range(0, 5));
        r.len_size = 4'(1 << $urandom_range(0, 3));
        r.len_val = ($urandom_range(0, 1) == 0)
                  ? qhpl_pkg::VAR_W'({$urandom, $urandom})
                  : qhpl_pkg::VAR_W'($urandom_range(0, 1500));
        r.trail = $urandom_range(0, 3);
        r.cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic push_datagram(input bit typed, input t_parse_result typed_res);
        t_parse_result got;
        int            last_idx;
        last_idx = dgram_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++) begin
            send_byte(dgram_bytes[i], i == last_idx);
            if (track_byte(dgram_bytes[i], i == last_idx, got)) begin
                awaited_results.push_back(typed ? typed_res : got);
            end
        end
    endtask

    task automatic load_cid(input logic [qhpl_pkg::CID_W-1:0] value);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.short_conn_id_length <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cid_bytes = value;
    endtask

    initial begin
        int n;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            n = idle_span();
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected transaction: packet_length %0d header_kind %0d status %0d",
                       res_ch.packet_length, res_ch.header_kind, res_ch.status);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.packet_length !== want.length) begin
                    $error("packet_length: expected %0d, actual %0d",
                           want.length, res_ch.packet_length);
                    mismatch_count++;
                end
                if (res_ch.header_kind !== want.kind) begin
                    $error("header_kind: expected %0d, actual %0d", want.kind, res_ch.header_kind);
                    mismatch_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [qhpl_pkg::CID_W-1:0] cid;
        int                         sent;
        int                         count;
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.short_conn_id_length <= '0;
        cid_bytes = qhpl_pkg::CID_LEN_RESET;
        reset_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            build_row(DIRECTED[i]);
            push_datagram(DIRECTED[i].typed,
                          '{DIRECTED[i].exp_len, DIRECTED[i].exp_kind, DIRECTED[i].exp_status});
        end
        byte_ch.valid <= 1'b0;

        // The first three phases pin the connection ID length to 0, 20 and the maximum 31.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       cid = 5'd0;
                1:       cid = 5'd20;
                2:       cid = 5'd31;
                default: cid = 5'($urandom_range(0, 31));
            endcase
            load_cid(cid);
            steady = (p == 3) || ($urandom_range(0, 4) == 0);
            sent = 0;
            count = 0;
            while (sent < 24 || count < 2) begin
                if ($urandom_range(0, 9) == 0) begin
                    dgram_bytes.delete();
                    repeat ($urandom_range(1, 20)) dgram_bytes.push_back(8'($urandom));
                end else begin
                    build_row(rand_row());
                end
                sent += dgram_bytes.size();
                count++;
                push_datagram(1'b0, '0);
            end
            byte_ch.valid <= 1'b0;
        end

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
